// File: src/imu_tlv_record_parser_defines.svh
// ---------------------------------------------------------------------------
// imu_tlv_record_parser_defines
// Assertion macros shared by the record parser checker.
// ---------------------------------------------------------------------------
`ifndef IMU_TLV_RECORD_PARSER_DEFINES_SVH
`define IMU_TLV_RECORD_PARSER_DEFINES_SVH

// Checked at every edge, reset included.
`define ITRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define ITRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: src/itrp_pkg.sv
// ---------------------------------------------------------------------------
// itrp_pkg
// Types, record ids and element layout of the record parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itrp_pkg;

  localparam logic [7:0]  MSG_ID_DATA    = 8'h36;
  localparam logic [15:0] ID_SAMPLE_TIME = 16'h1060;
  localparam logic [15:0] ID_UTC         = 16'h1010;
  localparam logic [15:0] ID_EULER       = 16'h2030;
  localparam logic [15:0] ID_QUAT        = 16'h2010;
  localparam logic [15:0] ID_ACC         = 16'h4020;
  localparam logic [15:0] ID_RATE        = 16'h8020;
  localparam logic [15:0] ID_LATLON      = 16'h5042;
  localparam logic [15:0] ID_ALTITUDE    = 16'h5022;
  localparam logic [15:0] ID_MAG         = 16'hC020;
  localparam logic [15:0] ID_STATUS      = 16'hE020;
  localparam logic [15:0] ID_VELOCITY    = 16'hD012;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_MSGID,
    PH_MSGLEN,
    PH_ID_HI,
    PH_ID_LO,
    PH_REC_LEN,
    PH_PAYLOAD
  } phase_t;

  // One classified payload byte on its way to the element assembler.
  typedef struct packed {
    logic [7:0]  byte_val;
    logic [15:0] record_id;
    logic [2:0]  elem_idx;
    logic [1:0]  pos;
    logic        start;
    logic        complete;
    logic        wide;
    logic        status;
    logic        record_done;
  } beat_t;

  // Byte size of element e of a record; zero when there is no such element.
  function automatic logic [2:0] elem_size(logic [15:0] id, logic [2:0] e);
    logic [2:0] sz;
    sz = 3'd0;
    case (id)
      ID_SAMPLE_TIME, ID_STATUS: sz = (e < 3'd1) ? 3'd4 : 3'd0;
      ID_UTC: begin
        if (e == 3'd0) sz = 3'd4;
        else if (e == 3'd1) sz = 3'd2;
        else if (e < 3'd7) sz = 3'd1;
        else sz = 3'd0;
      end
      ID_EULER, ID_ACC, ID_RATE, ID_MAG: sz = (e < 3'd3) ? 3'd4 : 3'd0;
      ID_QUAT:     sz = (e < 3'd4) ? 3'd4 : 3'd0;
      ID_LATLON:   sz = (e < 3'd2) ? 3'd6 : 3'd0;
      ID_ALTITUDE: sz = (e < 3'd1) ? 3'd6 : 3'd0;
      ID_VELOCITY: sz = (e < 3'd3) ? 3'd6 : 3'd0;
      default:     sz = 3'd0;
    endcase
    return sz;
  endfunction

endpackage

`default_nettype wire

// File: src/itrp_if.sv
// ---------------------------------------------------------------------------
// itrp_if
// Byte input channel and element result channel of the record parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       first_byte;

  modport source (output valid, rx_byte, first_byte, input ready);
  modport sink   (input valid, rx_byte, first_byte, output ready);
endinterface

interface itrp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] record_id;
  logic [2:0]  element_index;
  logic [47:0] element_value;
  logic        record_done;

  modport source (output valid, record_id, element_index, element_value, record_done,
                  input ready);
  modport sink   (input valid, record_id, element_index, element_value, record_done,
                  output ready);
endinterface

`default_nettype wire

// File: src/itrp_front.sv
// ---------------------------------------------------------------------------
// itrp_front
// Message framing: walks lead bytes, message header and record headers,
// and tags each payload byte that belongs to a known element.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itrp_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            first_byte,
  input  wire logic            q_full,
  output logic                 push,
  output itrp_pkg::beat_t      push_data
);

  itrp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  msg_left_r, msg_left_nxt;
  logic [7:0]  rec_left_r, rec_left_nxt;
  logic [15:0] id_r, id_nxt;
  logic [2:0]  ec_r, ec_nxt;
  logic [2:0]  fbc_r, fbc_nxt;

  logic       accept;
  logic       count_msg;
  logic [2:0] sz;
  logic [2:0] fbc_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign sz       = itrp_pkg::elem_size(id_r, ec_r);
  assign fbc_inc  = fbc_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= itrp_pkg::PH_IDLE;
      msg_left_r <= '0;
      rec_left_r <= '0;
      id_r       <= '0;
      ec_r       <= '0;
      fbc_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      msg_left_r <= msg_left_nxt;
      rec_left_r <= rec_left_nxt;
      id_r       <= id_nxt;
      ec_r       <= ec_nxt;
      fbc_r      <= fbc_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    msg_left_nxt = msg_left_r;
    rec_left_nxt = rec_left_r;
    id_nxt       = id_r;
    ec_nxt       = ec_r;
    fbc_nxt      = fbc_r;
    count_msg    = 1'b0;
    push         = 1'b0;

    push_data.byte_val    = rx_byte;
    push_data.record_id   = id_r;
    push_data.elem_idx    = ec_r;
    push_data.pos         = fbc_r[1:0];
    push_data.start       = (fbc_r == 3'd0);
    push_data.complete    = (fbc_inc == sz);
    push_data.wide        = (sz == 3'd6);
    push_data.status      = (id_r == itrp_pkg::ID_STATUS);
    push_data.record_done = (itrp_pkg::elem_size(id_r, ec_r + 3'd1) == 3'd0);

    if (accept) begin
      if (first_byte) begin
        // restart at the lead bytes, abandon anything in progress
        phase_nxt    = itrp_pkg::PH_LEAD;
        msg_left_nxt = '0;
        rec_left_nxt = '0;
        ec_nxt       = '0;
        fbc_nxt      = '0;
      end else begin
        case (phase_r)
          itrp_pkg::PH_IDLE: phase_nxt = itrp_pkg::PH_IDLE;
          itrp_pkg::PH_LEAD: phase_nxt = itrp_pkg::PH_MSGID;
          itrp_pkg::PH_MSGID: begin
            phase_nxt = (rx_byte == itrp_pkg::MSG_ID_DATA) ? itrp_pkg::PH_MSGLEN
                                                           : itrp_pkg::PH_IDLE;
          end
          itrp_pkg::PH_MSGLEN: begin
            msg_left_nxt = rx_byte;
            phase_nxt    = (rx_byte == 8'd0) ? itrp_pkg::PH_IDLE : itrp_pkg::PH_ID_HI;
          end
          itrp_pkg::PH_ID_HI: begin
            id_nxt    = {rx_byte, 8'h00};
            phase_nxt = itrp_pkg::PH_ID_LO;
            count_msg = 1'b1;
          end
          itrp_pkg::PH_ID_LO: begin
            id_nxt    = {id_r[15:8], rx_byte};
            phase_nxt = itrp_pkg::PH_REC_LEN;
            count_msg = 1'b1;
          end
          itrp_pkg::PH_REC_LEN: begin
            rec_left_nxt = rx_byte;
            ec_nxt       = '0;
            fbc_nxt      = '0;
            phase_nxt    = (rx_byte == 8'd0) ? itrp_pkg::PH_ID_HI : itrp_pkg::PH_PAYLOAD;
            count_msg    = 1'b1;
          end
          itrp_pkg::PH_PAYLOAD: begin
            if (sz != 3'd0) begin
              push = 1'b1;
              if (fbc_inc == sz) begin
                ec_nxt  = ec_r + 3'd1;
                fbc_nxt = '0;
              end else begin
                fbc_nxt = fbc_inc;
              end
            end
            rec_left_nxt = (rec_left_r != 8'd0) ? rec_left_r - 8'd1 : rec_left_r;
            if (rec_left_nxt == 8'd0) phase_nxt = itrp_pkg::PH_ID_HI;
            count_msg = 1'b1;
          end
          default: phase_nxt = itrp_pkg::PH_IDLE;
        endcase

        if (count_msg) begin
          msg_left_nxt = (msg_left_r != 8'd0) ? msg_left_r - 8'd1 : msg_left_r;
          if (msg_left_nxt == 8'd0) phase_nxt = itrp_pkg::PH_IDLE;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/itrp_fifo.sv
// ---------------------------------------------------------------------------
// itrp_fifo
// Short queue of classified payload bytes between framing and assembly.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itrp_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire itrp_pkg::beat_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output itrp_pkg::beat_t      pop_data,
  output logic                 not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  itrp_pkg::beat_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      if (do_push && !do_pop) count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/itrp_back.sv
// ---------------------------------------------------------------------------
// itrp_back
// Element assembly: gathers tagged bytes into words and FP16.32 values
// and holds each finished element in the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itrp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire itrp_pkg::beat_t q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [15:0]          record_id,
  output logic [2:0]           element_index,
  output logic [47:0]          element_value,
  output logic                 record_done
);

  logic [47:0] acc_r, acc_nxt;
  logic [47:0] base, assembled, finished;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] rec_id_r;
  logic [2:0]  idx_r;
  logic [47:0] value_r;
  logic        done_r;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = q_valid && (!q_data.complete || out_free);

  always_comb begin
    base = q_data.start ? 48'd0 : acc_r;
    if (q_data.status) begin
      assembled = base | (48'(q_data.byte_val) << {q_data.pos, 3'b000});
    end else begin
      assembled = {base[39:0], q_data.byte_val};
    end
    finished = q_data.wide ? {assembled[15:0], assembled[47:16]} : assembled;
    acc_nxt  = acc_r;
    if (pop) acc_nxt = q_data.complete ? 48'd0 : assembled;

    out_valid_nxt = out_valid_r && !out_ready;
    if (pop && q_data.complete) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (pop && q_data.complete) begin
      rec_id_r <= q_data.record_id;
      idx_r    <= q_data.elem_idx;
      value_r  <= finished;
      done_r   <= q_data.record_done;
    end
  end

  assign out_valid     = out_valid_r;
  assign record_id     = rec_id_r;
  assign element_index = idx_r;
  assign element_value = value_r;
  assign record_done   = done_r;

endmodule

`default_nettype wire

// File: src/imu_tlv_record_parser.sv
// ---------------------------------------------------------------------------
// imu_tlv_record_parser
// Byte-serial parser for sensor data messages built of id/length records.
//
//   channel | dir | payload                                       | handshake
//   in_ch   | in  | rx_byte[8], first_byte[1]                     | valid/ready
//   out_ch  | out | record_id[16], element_index[3],              | valid/ready
//           |     | element_value[48], record_done[1]             |
//
// One byte is taken per cycle unless the byte queue is full; the framing stage
// is the only loop over state; a finished element waits in the output register.
// Reset is synchronous; no clearing pass, the block is ready right after reset.
// A stalled result fills the byte queue (QUEUE_DEPTH entries) before in_ch
// drops ready; while the queue is full every byte waits, header bytes too.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_tlv_record_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  itrp_in_if.sink    in_ch,
  itrp_out_if.source out_ch
);

  itrp_pkg::beat_t push_data, pop_data;
  logic push, q_full, pop, q_valid;

  itrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .rx_byte    (in_ch.rx_byte),
    .first_byte (in_ch.first_byte),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  itrp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  itrp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (pop_data),
    .pop           (pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .record_id     (out_ch.record_id),
    .element_index (out_ch.element_index),
    .element_value (out_ch.element_value),
    .record_done   (out_ch.record_done)
  );

endmodule

`default_nettype wire

// File: src/itrp_checker.sv
// ---------------------------------------------------------------------------
// itrp_checker
// Port-level checks of the record parser result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "imu_tlv_record_parser_defines.svh"

module itrp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] record_id,
  input wire logic [2:0]  element_index,
  input wire logic [47:0] element_value,
  input wire logic        record_done
);

  logic        stalled;
  logic        single_id;
  logic        word_id;
  logic [67:0] result_bits;

  assign stalled     = out_valid && !out_ready;
  assign result_bits = {record_id, element_index, element_value, record_done};
  assign single_id   = (record_id == itrp_pkg::ID_SAMPLE_TIME) ||
                       (record_id == itrp_pkg::ID_STATUS) ||
                       (record_id == itrp_pkg::ID_ALTITUDE);
  assign word_id     = (record_id == itrp_pkg::ID_EULER) ||
                       (record_id == itrp_pkg::ID_QUAT) ||
                       (record_id == itrp_pkg::ID_STATUS);

  `ITRP_ASSERT(a_hold, stalled |=> out_valid && $stable(result_bits), "held result changed")
  `ITRP_ASSERT_ALWAYS(a_rst, !rst_n |=> !out_valid, "result valid after reset")
  `ITRP_ASSERT(a_idx, out_valid |-> element_index != 3'd7, "element index out of range")
  `ITRP_ASSERT(a_single, out_valid && single_id |-> record_done, "single-element record not done")
  `ITRP_ASSERT(a_word, out_valid && word_id |-> element_value[47:32] == 16'd0, "upper bits set")

endmodule

bind imu_tlv_record_parser itrp_checker u_itrp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .record_id     (out_ch.record_id),
  .element_index (out_ch.element_index),
  .element_value (out_ch.element_value),
  .record_done   (out_ch.record_done)
);

`default_nettype wire

// File: tb/tb_imu_tlv_record_parser.sv
// ---------------------------------------------------------------------------
// tb_imu_tlv_record_parser
// Self-checking bench for the byte-serial record parser. Streams directed and
// random sensor messages (good, cut short, abandoned, wrong id, unknown and
// odd-sized records) through the byte channel. A local parser model predicts
// every element, and each element transfer is checked in order, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_imu_tlv_record_parser;

  localparam int RANDOM_BYTES = 1700;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [15:0] KNOWN_IDS [11] = '{
    itrp_pkg::ID_SAMPLE_TIME, itrp_pkg::ID_UTC, itrp_pkg::ID_EULER, itrp_pkg::ID_QUAT,
    itrp_pkg::ID_ACC, itrp_pkg::ID_RATE, itrp_pkg::ID_LATLON, itrp_pkg::ID_ALTITUDE,
    itrp_pkg::ID_MAG, itrp_pkg::ID_STATUS, itrp_pkg::ID_VELOCITY
  };

  typedef struct packed {
    logic [7:0] data;
    logic       lead;
  } stream_byte_t;

  typedef struct packed {
    logic [15:0] rid;
    logic [2:0]  idx;
    logic [47:0] val;
    logic        done;
  } element_t;

  logic clk;
  logic rst_n;

  itrp_in_if  in_if ();
  itrp_out_if out_if ();

  imu_tlv_record_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  stream_byte_t byte_q [$];
  element_t     element_q [$];

  int total_bytes;
  int bytes_sent;
  int messages;
  int elements_seen;
  int records_closed;
  int errors;
  int cycles;
  int hold_left;
  bit hold_done;

  // Parser model state
  itrp_pkg::phase_t ph;
  logic [7:0]  msg_left;
  logic [7:0]  rec_left;
  logic [15:0] rid;
  logic [47:0] acc;
  logic [2:0]  nbytes;
  logic [2:0]  nelem;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Byte width of element k of a record; zero past the end of its layout.
  function automatic logic [2:0] field_width(logic [15:0] id, logic [2:0] k);
    int         count;
    logic [2:0] w;
    count = 0;
    w = 3'd4;
    case (id)
      itrp_pkg::ID_SAMPLE_TIME, itrp_pkg::ID_STATUS: count = 1;
      itrp_pkg::ID_EULER, itrp_pkg::ID_ACC, itrp_pkg::ID_RATE, itrp_pkg::ID_MAG: count = 3;
      itrp_pkg::ID_QUAT: count = 4;
      itrp_pkg::ID_LATLON: begin
        count = 2;
        w = 3'd6;
      end
      itrp_pkg::ID_ALTITUDE: begin
        count = 1;
        w = 3'd6;
      end
      itrp_pkg::ID_VELOCITY: begin
        count = 3;
        w = 3'd6;
      end
      itrp_pkg::ID_UTC: begin
        count = 7;
        w = (k == 3'd0) ? 3'd4 : (k == 3'd1) ? 3'd2 : 3'd1;
      end
      default: count = 0;
    endcase
    return (int'(k) < count) ? w : 3'd0;
  endfunction

  function automatic int layout_bytes(logic [15:0] id);
    int sum;
    sum = 0;
    for (int k = 0; k < 8; k++) sum += field_width(id, 3'(k));
    return sum;
  endfunction

  task automatic parse_byte(input logic [7:0] data, input logic lead);
    element_t   e;
    logic [2:0] w;
    logic       emit;
    emit = 1'b0;
    if (lead) begin
      ph = itrp_pkg::PH_LEAD;
      msg_left = '0;
      rec_left = '0;
      acc = '0;
      nbytes = '0;
      nelem = '0;
    end else begin
      case (ph)
        itrp_pkg::PH_IDLE: ;
        itrp_pkg::PH_LEAD: ph = itrp_pkg::PH_MSGID;
        itrp_pkg::PH_MSGID: begin
          ph = (data == itrp_pkg::MSG_ID_DATA) ? itrp_pkg::PH_MSGLEN : itrp_pkg::PH_IDLE;
        end
        itrp_pkg::PH_MSGLEN: begin
          msg_left = data;
          ph = (data == 8'd0) ? itrp_pkg::PH_IDLE : itrp_pkg::PH_ID_HI;
        end
        default: begin
          case (ph)
            itrp_pkg::PH_ID_HI: begin
              rid = {data, 8'h00};
              ph = itrp_pkg::PH_ID_LO;
            end
            itrp_pkg::PH_ID_LO: begin
              rid[7:0] = data;
              ph = itrp_pkg::PH_REC_LEN;
            end
            itrp_pkg::PH_REC_LEN: begin
              rec_left = data;
              acc = '0;
              nbytes = '0;
              nelem = '0;
              ph = (data == 8'd0) ? itrp_pkg::PH_ID_HI : itrp_pkg::PH_PAYLOAD;
            end
            default: begin
              w = field_width(rid, nelem);
              if (w != 3'd0) begin
                // status word arrives low byte first, all others high byte first
                if (rid == itrp_pkg::ID_STATUS) begin
                  acc = acc | (48'(data) << (8 * nbytes[1:0]));
                end else begin
                  acc = {acc[39:0], data};
                end
                nbytes = nbytes + 3'd1;
                if (nbytes == w) begin
                  e.rid = rid;
                  e.idx = nelem;
                  e.val = (w == 3'd6) ? {acc[15:0], acc[47:16]} : acc;
                  e.done = (field_width(rid, nelem + 3'd1) == 3'd0);
                  emit = 1'b1;
                  nelem = nelem + 3'd1;
                  nbytes = '0;
                  acc = '0;
                end
              end
              if (rec_left != 8'd0) rec_left = rec_left - 8'd1;
              if (rec_left == 8'd0) ph = itrp_pkg::PH_ID_HI;
            end
          endcase
          if (msg_left != 8'd0) msg_left = msg_left - 8'd1;
          if (msg_left == 8'd0) ph = itrp_pkg::PH_IDLE;
        end
      endcase
    end
    if (emit) element_q.push_back(e);
  endtask

  task automatic push_byte(input logic [7:0] data, input logic lead);
    stream_byte_t s;
    s.data = data;
    s.lead = lead;
    byte_q.push_back(s);
  endtask

  function automatic logic [7:0] payload_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic queue_message();
    logic [7:0]  body [$];
    logic [15:0] id;
    logic [7:0]  msg_id;
    int          nominal;
    int          len;
    int          nrec;
    int          kind;
    int          mlen;
    int          keep;
    messages++;
    push_byte(8'($urandom), 1'b1);
    push_byte(8'($urandom), 1'b0);
    if ($urandom_range(0, 99) < 6) begin
      msg_id = 8'($urandom);
      if (msg_id == itrp_pkg::MSG_ID_DATA) msg_id = msg_id ^ 8'h01;
      push_byte(msg_id, 1'b0);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
      return;
    end
    push_byte(itrp_pkg::MSG_ID_DATA, 1'b0);
    nrec = $urandom_range(1, 6);
    for (int i = 0; i < nrec; i++) begin
      if ($urandom_range(0, 99) < 85) id = KNOWN_IDS[$urandom_range(0, 10)];
      else id = 16'($urandom);
      nominal = layout_bytes(id);
      kind = $urandom_range(0, 99);
      if (nominal == 0) len = $urandom_range(0, 12);
      else if (kind < 75) len = nominal;
      else if (kind < 85) len = nominal + $urandom_range(1, 4);
      else if (kind < 95) len = $urandom_range(0, nominal - 1);
      else len = 0;
      if (body.size() + 3 + len > 247) break;
      body.push_back(id[15:8]);
      body.push_back(id[7:0]);
      body.push_back(8'(len));
      repeat (len) body.push_back(payload_value());
    end
    kind = $urandom_range(0, 99);
    keep = body.size();
    mlen = body.size();
    if (kind < 6) begin
      mlen = 0;
      keep = 0;
    end else if (kind < 14) begin
      mlen = $urandom_range(1, body.size());
    end else if (kind < 22) begin
      mlen = body.size() + $urandom_range(1, 8);
    end else if (kind < 30) begin
      keep = $urandom_range(0, body.size());
    end
    push_byte(8'(mlen), 1'b0);
    for (int i = 0; i < keep; i++) push_byte(body[i], 1'b0);
  endtask

  function automatic int sender_gap_pct();
    if (bytes_sent < total_bytes / 3) return 38;
    if (bytes_sent < 2 * total_bytes / 3) return 46;
    return 0;
  endfunction

  function automatic int receiver_gap_pct();
    if (bytes_sent < total_bytes / 3) return 46;
    if (bytes_sent < 2 * total_bytes / 3) return 38;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : drive_bytes
    stream_byte_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.rx_byte, in_if.first_byte);
        bytes_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_q.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
          nxt = byte_q.pop_front();
          in_if.valid      <= 1'b1;
          in_if.rx_byte    <= nxt.data;
          in_if.first_byte <= nxt.lead;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_elements
    element_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        elements_seen++;
        if (out_if.record_done) records_closed++;
        if (element_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected element, expected none, actual id %h idx %0d value %h",
                   $time, out_if.record_id, out_if.element_index, out_if.element_value);
        end else begin
          want = element_q.pop_front();
          check_field("record_id", 48'(want.rid), 48'(out_if.record_id));
          check_field("element_index", 48'(want.idx), 48'(out_if.element_index));
          check_field("element_value", want.val, out_if.element_value);
          check_field("record_done", 48'(want.done), 48'(out_if.record_done));
        end
      end
      // hold off once for a long stretch so the byte queue fills
      if (!hold_done && bytes_sent >= 3 * total_bytes / 4) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= receiver_gap_pct());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d bytes sent, %0d elements pending",
               cycles, bytes_sent, total_bytes, element_q.size());
      $display("FAIL imu_tlv_record_parser");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'h00;
    in_if.first_byte = 1'b0;
    out_if.ready = 1'b0;
    ph = itrp_pkg::PH_IDLE;
    msg_left = '0;
    rec_left = '0;
    rid = '0;
    acc = '0;
    nbytes = '0;
    nelem = '0;

    // stray byte while idle, wrong message id, zero-length message
    push_byte(8'h5A, 1'b0);
    push_byte(8'hFA, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h37, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(itrp_pkg::MSG_ID_DATA, 1'b0);
    push_byte(8'h00, 1'b0);
    // negative altitude, then an unknown one-byte record that ends the message
    push_byte(8'hFA, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(itrp_pkg::MSG_ID_DATA, 1'b0);
    push_byte(8'd13, 1'b0);
    push_byte(itrp_pkg::ID_ALTITUDE[15:8], 1'b0);
    push_byte(itrp_pkg::ID_ALTITUDE[7:0], 1'b0);
    push_byte(8'd6, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'hAB, 1'b0);
    messages = 3;

    while (byte_q.size() < 25 + RANDOM_BYTES) queue_message();
    total_bytes = byte_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent < total_bytes) @(posedge clk);
    while (element_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (element_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected elements never arrived", $time, element_q.size());
    end
    $display("streamed %0d bytes in %0d messages over %0d cycles", bytes_sent, messages,
             cycles);
    $display("checked %0d elements, %0d of them closing a record, %0d mismatches",
             elements_seen, records_closed, errors);
    if (errors == 0) begin
      $display("PASS imu_tlv_record_parser");
    end else begin
      $display("FAIL imu_tlv_record_parser");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/itrp_pkg.sv
src/itrp_if.sv
src/itrp_front.sv
src/itrp_fifo.sv
src/itrp_back.sv
src/imu_tlv_record_parser.sv
src/itrp_checker.sv
tb/tb_imu_tlv_record_parser.sv
